>>> hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the tcp segmenter with checksum.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [7:0]  FLAG_ACK = 8'h10;
    localparam logic [7:0]  FLAG_PSH = 8'h08;
    localparam logic [15:0] STEP_MOD = 16'd97;
    localparam logic [31:0] RCP_97 = 32'd708448213;   // floor(2^36 / 97)
    localparam logic [18:0] STEP_BIAS = 19'd48;
    localparam logic [7:0]  HDR_OFFSET = 8'h50;
    localparam logic [31:0] PSEUDO_CONST = 32'd26;   // protocol 6 plus header length 20

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_SRC_PORT  = 3'd0;
    localparam logic [2:0] REG_DST_PORT  = 3'd1;
    localparam logic [2:0] REG_SRC_ADDR  = 3'd2;
    localparam logic [2:0] REG_DST_ADDR  = 3'd3;
    localparam logic [2:0] REG_MAX_SEG   = 3'd4;
    localparam logic [2:0] REG_WIN_FLOOR = 3'd5;
    localparam logic [2:0] REG_WIN_CEIL  = 3'd6;
    localparam logic [2:0] REG_INIT_SEQ  = 3'd7;

    localparam logic [15:0] MAX_SEG_RST   = 16'd1400;
    localparam logic [15:0] WIN_FLOOR_RST = 16'd16384;
    localparam logic [15:0] WIN_CEIL_RST  = 16'd65535;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] len;
        logic        last;
        logic        gap;
        logic        refresh;
        logic [31:0] psum;
    } t_desc;

endpackage

>>> hw/rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Takes payload beats, sums byte pairs and cuts segments into descriptors.
// ----------------------------------------------------------------------------
module tsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic [47:0]      i_now,
    input  logic [31:0]      i_ack,
    input  logic             i_refresh,
    input  logic [15:0]      i_max_seg,
    input  logic             i_seq_load,
    input  logic [31:0]      i_seq_value,
    input  logic             i_q_full,
    output logic             o_push,
    output tsc_pkg::t_desc   o_desc
);
    import tsc_pkg::*;

    logic        r_in_rec;
    logic [31:0] r_next_seq;
    logic [47:0] r_last_time;
    logic [47:0] r_rec_time;
    logic [31:0] r_rec_ack;
    logic        r_refresh;
    logic        r_gap;
    logic [31:0] r_offset;
    logic [15:0] r_cnt;
    logic [31:0] r_psum;
    logic [8:0]  r_odd;

    logic        accept, start, emit;
    logic [47:0] rec_time;
    logic [31:0] rec_ack;
    logic        refr, gap;
    logic [31:0] off_b, n_offset;
    logic [15:0] cnt_b, n_cnt, limit;
    logic [31:0] psum_b, n_psum;
    logic [8:0]  odd_b, n_odd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign start   = !r_in_rec;

    always_comb begin
        rec_time = start ? i_now : r_rec_time;
        rec_ack  = start ? i_ack : r_rec_ack;
        refr     = start ? i_refresh : r_refresh;
        gap      = start ? ({1'b0, i_now} >= ({1'b0, r_last_time} + 49'd5)) : r_gap;
        off_b    = start ? 32'd0 : r_offset;
        cnt_b    = start ? 16'd0 : r_cnt;
        psum_b   = start ? 32'd0 : r_psum;
        odd_b    = start ? 9'd0 : r_odd;
        if (odd_b[8]) begin
            n_psum = psum_b + {16'd0, odd_b[7:0], i_byte};
            n_odd  = 9'd0;
        end else begin
            n_psum = psum_b;
            n_odd  = {1'b1, i_byte};
        end
        n_cnt    = cnt_b + 16'd1;
        n_offset = off_b + 32'd1;
        limit    = (i_max_seg == 16'd0) ? 16'd1 : i_max_seg;
        emit     = (n_cnt >= limit) || i_last;

        o_desc.seq     = r_next_seq + n_offset - {16'd0, n_cnt};
        o_desc.ack     = rec_ack;
        o_desc.len     = n_cnt;
        o_desc.last    = i_last;
        o_desc.gap     = gap;
        o_desc.refresh = refr;
        o_desc.psum    = n_psum + (n_odd[8] ? {16'd0, n_odd[7:0], 8'd0} : 32'd0);
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rec    <= 1'b0;
            r_next_seq  <= 32'd0;
            r_last_time <= 48'd0;
            r_refresh   <= 1'b0;
            r_gap       <= 1'b0;
            r_offset    <= 32'd0;
            r_cnt       <= 16'd0;
            r_psum      <= 32'd0;
            r_odd       <= 9'd0;
        end else begin
            if (i_seq_load) begin
                r_next_seq <= i_seq_value;
            end
            if (accept) begin
                r_rec_time <= rec_time;
                r_rec_ack  <= rec_ack;
                r_gap      <= gap;
                if (emit) begin
                    r_cnt     <= 16'd0;
                    r_psum    <= 32'd0;
                    r_odd     <= 9'd0;
                    r_refresh <= 1'b0;
                end else begin
                    r_cnt     <= n_cnt;
                    r_psum    <= n_psum;
                    r_odd     <= n_odd;
                    r_refresh <= refr;
                end
                if (i_last) begin
                    r_next_seq  <= r_next_seq + n_offset;
                    r_last_time <= rec_time;
                    r_offset    <= 32'd0;
                    r_in_rec    <= 1'b0;
                end else begin
                    r_offset <= n_offset;
                    r_in_rec <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Small descriptor queue between the segment cutter and the header builder.
// ----------------------------------------------------------------------------
module tsc_queue #(
    parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tsc_pkg::t_desc   i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output tsc_pkg::t_desc   o_data
);
    import tsc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Builds one header per descriptor: flags, window walk and checksum.
// ----------------------------------------------------------------------------
module tsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tsc_pkg::t_desc   i_q_data,
    output logic             o_pop,
    input  logic [15:0]      i_src_port,
    input  logic [15:0]      i_dst_port,
    input  logic [31:0]      i_src_addr,
    input  logic [31:0]      i_dst_addr,
    input  logic [15:0]      i_win_floor,
    input  logic [15:0]      i_win_ceil,
    input  logic [31:0]      i_init_seq,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_seq,
    output logic [31:0]      o_ack,
    output logic [7:0]       o_flags,
    output logic [15:0]      o_window,
    output logic [15:0]      o_checksum,
    output logic [15:0]      o_len,
    output logic             o_last
);
    import tsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CSUM, S_MUL, S_DIV, S_RCP, S_RED, S_FIX, S_WIN, S_OUT
    } t_state;

    t_state      r_state;
    t_desc       r_d;
    logic [7:0]  r_flags;
    logic [2:0]  r_pc;
    logic [15:0] r_win;
    logic [63:0] r_gen;
    logic        r_seeding, r_step_pending;
    logic [31:0] r_part;
    logic [1:0]  r_mi;
    logic [63:0] r_mul_a, r_acc, r_prod;
    logic [30:0] r_dvd;
    logic [15:0] r_rem, r_divisor;
    logic [4:0]  r_div_cnt;

    logic [31:0] mul_x, mul_y;
    logic [63:0] prod, acc_add, gen_new;
    logic [16:0] rem_sh;
    logic [31:0] red_q, red_r;
    logic [2:0]  pc_inc;
    logic [31:0] part, sum_all, fold1, fold2;
    logic signed [18:0] v0, v1, v2;
    logic        span_ok;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign span_ok = i_win_ceil > i_win_floor;

    always_comb begin
        if (r_state == S_RCP) begin
            // reciprocal of 97 for the step remainder
            mul_x = {1'b0, r_dvd};
            mul_y = RCP_97;
        end else begin
            unique case (r_mi)
                2'd0:    begin mul_x = r_mul_a[31:0];  mul_y = LCG_MUL[31:0];  end
                2'd1:    begin mul_x = r_mul_a[31:0];  mul_y = LCG_MUL[63:32]; end
                default: begin mul_x = r_mul_a[63:32]; mul_y = LCG_MUL[31:0];  end
            endcase
        end
        prod    = {32'd0, mul_x} * {32'd0, mul_y};
        acc_add = (r_mi == 2'd1) ? r_prod : {r_prod[31:0], 32'd0};
        gen_new = r_acc + acc_add;

        rem_sh = {r_rem, r_dvd[30]};

        // quotient estimate is exact or one low
        red_q = {4'd0, r_prod[63:36]};
        red_r = {1'b0, r_dvd} - red_q * {16'd0, STEP_MOD};

        pc_inc = r_pc + 3'd1;

        part = r_d.psum
             + {16'd0, i_src_addr[31:16]} + {16'd0, i_src_addr[15:0]}
             + {16'd0, i_dst_addr[31:16]} + {16'd0, i_dst_addr[15:0]}
             + PSEUDO_CONST + {16'd0, r_d.len}
             + {16'd0, i_src_port} + {16'd0, i_dst_port}
             + {16'd0, r_d.seq[31:16]} + {16'd0, r_d.seq[15:0]}
             + {16'd0, r_d.ack[31:16]} + {16'd0, r_d.ack[15:0]};

        sum_all = r_part + {16'd0, HDR_OFFSET, r_flags} + {16'd0, r_win};
        fold1   = {16'd0, sum_all[15:0]} + {16'd0, sum_all[31:16]};
        fold2   = {16'd0, fold1[15:0]} + {16'd0, fold1[31:16]};

        // reflect at ceiling, then at floor
        v0 = $signed({3'd0, r_win}) + $signed({3'd0, r_rem}) - $signed(STEP_BIAS);
        v1 = (v0 > $signed({3'd0, i_win_ceil})) ? $signed({2'd0, i_win_ceil, 1'b0}) - v0 : v0;
        v2 = (v1 < $signed({3'd0, i_win_floor})) ? $signed({2'd0, i_win_floor, 1'b0}) - v1 : v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pc           <= 3'd0;
            r_win          <= 16'd0;
            r_gen          <= 64'd0;
            r_seeding      <= 1'b0;
            r_step_pending <= 1'b0;
            r_mi           <= 2'd0;
            r_div_cnt      <= 5'd0;
            o_valid        <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_d     <= i_q_data;
                        r_state <= S_CSUM;
                    end
                end
                S_CSUM: begin
                    r_part <= part;
                    if (r_d.gap || pc_inc >= 3'd6) begin
                        r_pc    <= 3'd0;
                        r_flags <= FLAG_PSH | FLAG_ACK;
                    end else begin
                        r_pc    <= pc_inc;
                        r_flags <= FLAG_ACK;
                    end
                    r_acc <= LCG_ADD;
                    r_mi  <= 2'd0;
                    if (r_win == 16'd0) begin
                        r_mul_a        <= {32'd0, i_init_seq ^ {16'd0, i_dst_port}};
                        r_seeding      <= 1'b1;
                        r_step_pending <= r_d.refresh;
                        r_state        <= S_MUL;
                    end else if (r_d.refresh) begin
                        r_mul_a        <= r_gen;
                        r_seeding      <= 1'b0;
                        r_step_pending <= 1'b0;
                        r_state        <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    r_prod <= prod;
                    if (r_mi != 2'd0) begin
                        r_acc <= gen_new;
                    end
                    if (r_mi == 2'd3) begin
                        r_gen     <= gen_new;
                        r_rem     <= 16'd0;
                        r_div_cnt <= 5'd0;
                        if (r_seeding) begin
                            r_dvd     <= gen_new[63:33];
                            r_divisor <= span_ok ? (i_win_ceil - i_win_floor) : 16'd1;
                            r_state   <= S_DIV;
                        end else begin
                            r_dvd   <= {2'd0, gen_new[63:35]};
                            r_state <= S_RCP;
                        end
                    end else begin
                        r_mi <= r_mi + 2'd1;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sh >= {1'b0, r_divisor}) begin
                        r_rem <= 16'(rem_sh - {1'b0, r_divisor});
                    end else begin
                        r_rem <= rem_sh[15:0];
                    end
                    r_dvd     <= {r_dvd[29:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd30) begin
                        r_state <= S_WIN;
                    end
                end
                S_RCP: begin
                    r_prod  <= prod;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem   <= red_r[15:0];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_rem >= STEP_MOD) begin
                        r_rem <= r_rem - STEP_MOD;
                    end
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    if (r_seeding) begin
                        r_win <= span_ok ? (i_win_floor + r_rem) : i_win_floor;
                        if (r_step_pending) begin
                            r_mul_a        <= r_gen;
                            r_seeding      <= 1'b0;
                            r_step_pending <= 1'b0;
                            r_acc          <= LCG_ADD;
                            r_mi           <= 2'd0;
                            r_state        <= S_MUL;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_win   <= v2[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_seq      <= r_d.seq;
                        o_ack      <= r_d.ack;
                        o_flags    <= r_flags;
                        o_window   <= r_win;
                        o_checksum <= ~fold2[15:0];
                        o_len      <= r_d.len;
                        o_last     <= r_d.last;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/tcp_segmenter_with_checksum_top.sv
// ----------------------------------------------------------------------------
// tcp_segmenter_with_checksum_top
// Cuts a byte stream of records into segments and emits one header per segment.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one payload byte a beat; tlast marks the last byte of a
//   record, time and ack are taken from the record's first beat, tuser asks
//   for one window step. m_axis gives one header descriptor per segment,
//   tlast set on the record's last segment. apb port holds the registers.
// throughput: one payload byte a cycle while the descriptor queue has room.
//   each segment's header work is the checksum, then the output; a seed
//   adds a generator step on the 32x32 multiplier and the serial
//   remainder unit, a step adds a generator step and the reciprocal
//   remainder (reciprocal multiply, reduce, fix), and a segment with both
//   takes the seed first, then the step. The header builder takes the next
//   descriptor only once the last header is loaded onto m_axis.
// reset: registers return to defaults, sequence state is zero, window unseeded.
// stall: a held m_axis keeps its header; the queue fills, then s_axis_tready
//   drops until the header builder moves on.
module tcp_segmenter_with_checksum_top #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [87:0]                s_axis_tdata,  // data_byte, now_ms, ack_number
    input  logic                       s_axis_tlast,
    input  logic                       s_axis_tuser,  // window_refresh
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // segment_seq, segment_ack, tcp_flags, window, checksum, payload_length
    output logic [119:0]               m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tsc_pkg::*;

    logic [15:0] r_src_port, r_dst_port, r_max_seg, r_win_floor, r_win_ceil;
    logic [31:0] r_src_addr, r_dst_addr, r_init_seq;
    logic        wr_en, seq_load;
    logic [2:0]  reg_idx;

    logic  q_push, q_full, q_pop, q_valid;
    t_desc q_in, q_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign seq_load = wr_en && (reg_idx == REG_INIT_SEQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_port  <= 16'd0;
            r_dst_port  <= 16'd0;
            r_src_addr  <= 32'd0;
            r_dst_addr  <= 32'd0;
            r_max_seg   <= MAX_SEG_RST;
            r_win_floor <= WIN_FLOOR_RST;
            r_win_ceil  <= WIN_CEIL_RST;
            r_init_seq  <= 32'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SRC_PORT:  r_src_port  <= pwdata[15:0];
                REG_DST_PORT:  r_dst_port  <= pwdata[15:0];
                REG_SRC_ADDR:  r_src_addr  <= pwdata;
                REG_DST_ADDR:  r_dst_addr  <= pwdata;
                REG_MAX_SEG:   r_max_seg   <= pwdata[15:0];
                REG_WIN_FLOOR: r_win_floor <= pwdata[15:0];
                REG_WIN_CEIL:  r_win_ceil  <= pwdata[15:0];
                REG_INIT_SEQ:  r_init_seq  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_PORT:  prdata = {16'd0, r_src_port};
            REG_DST_PORT:  prdata = {16'd0, r_dst_port};
            REG_SRC_ADDR:  prdata = r_src_addr;
            REG_DST_ADDR:  prdata = r_dst_addr;
            REG_MAX_SEG:   prdata = {16'd0, r_max_seg};
            REG_WIN_FLOOR: prdata = {16'd0, r_win_floor};
            REG_WIN_CEIL:  prdata = {16'd0, r_win_ceil};
            REG_INIT_SEQ:  prdata = r_init_seq;
            default:       prdata = 32'd0;
        endcase
    end

    tsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_now       (s_axis_tdata[55:8]),
        .i_ack       (s_axis_tdata[87:56]),
        .i_refresh   (s_axis_tuser),
        .i_max_seg   (r_max_seg),
        .i_seq_load  (seq_load),
        .i_seq_value (pwdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (q_in)
    );

    tsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    tsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_pop       (q_pop),
        .i_src_port  (r_src_port),
        .i_dst_port  (r_dst_port),
        .i_src_addr  (r_src_addr),
        .i_dst_addr  (r_dst_addr),
        .i_win_floor (r_win_floor),
        .i_win_ceil  (r_win_ceil),
        .i_init_seq  (r_init_seq),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_seq       (m_axis_tdata[31:0]),
        .o_ack       (m_axis_tdata[63:32]),
        .o_flags     (m_axis_tdata[71:64]),
        .o_window    (m_axis_tdata[87:72]),
        .o_checksum  (m_axis_tdata[103:88]),
        .o_len       (m_axis_tdata[119:104]),
        .o_last      (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("descriptor pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("descriptor popped from empty queue");
    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == !q_full) else $error("input ready disagrees with queue room");
`endif

endmodule
